FILE: sv/wcm_pkg.sv
// Shared types, field widths and codes for the wall column texel mapper.
package wcm_pkg;

	localparam int DIST_W      = 20;
	localparam int FRAC_W      = 16;
	localparam int FACE_W      = 2;
	localparam int COL_W       = 12;
	localparam int ROW_W       = 11;
	localparam int HEIGHT_W    = 12;
	localparam int COLOR_W     = 24;
	localparam int TEXEL_W     = 6;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CEILING_COLOR = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR_COLOR   = 2'd2;

	localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RST = 12'd720;

	typedef enum logic [1:0] {
		REGION_CEILING,
		REGION_WALL,
		REGION_FLOOR,
		REGION_OUTSIDE
	} region_t;

	typedef struct packed {
		logic [DIST_W-1:0] wall_distance;
		logic [FRAC_W-1:0] hit_fraction;
		logic [FACE_W-1:0] wall_face;
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
	} req_word_t;

	typedef struct packed {
		region_t            region;
		logic [COLOR_W-1:0] flat_color;
		logic [TEXEL_W-1:0] texel_x;
		logic [TEXEL_W-1:0] texel_y;
		logic [FACE_W-1:0]  face_out;
		logic [COL_W-1:0]   column_out;
	} rsp_word_t;

	// fields that ride along the pipe untouched
	typedef struct packed {
		logic [FACE_W-1:0]  wall_face;
		logic [COL_W-1:0]   column;
		logic [TEXEL_W-1:0] texel_x;
	} wcm_pass_t;

endpackage

FILE: sv/wall_column_texel_mapper_unit.sv
// Top level of the wall column texel mapper: config registers, front stage, dividers, output.
//
// Maps one screen pixel of a textured wall column per word: region (ceiling, wall, floor,
// outside), flat color and texel coordinates. The block is fully pipelined and takes one
// request word every clock unless the response side stalls. LW = clog2(MAX_ROWS+1) + 5 is
// the stage count of the strip height divider and QW = clog2(TEX_SIZE+1) the stage count of
// the texel row divider. A stall on the response side holds the whole pipe in place; nothing
// is dropped or repeated. Configuration registers take effect immediately and should only be
// written while no request is in flight.
module wall_column_texel_mapper_unit
	import wcm_pkg::*;
#(
	parameter int TEX_SIZE       = 64,
	parameter int MAX_ROWS       = 2048,
	parameter int DIST_FRAC_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  req_word_t              req,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output rsp_word_t              rsp
);

	localparam int HW       = $clog2(MAX_ROWS + 1);
	localparam int NW       = HW + DIST_FRAC_BITS;
	localparam int LW       = HW + 5;
	localparam int QW       = $clog2(TEX_SIZE + 1);
	localparam int DIST_MIN = ((2 ** DIST_FRAC_BITS) * 5 + 50) / 100;
	localparam int PASS_W   = $bits(wcm_pass_t);
	localparam int SIDE1_W  = PASS_W + ROW_W + HW;
	localparam int SIDE2_W  = PASS_W + $bits(region_t);
	localparam int PW       = FRAC_W + QW;

	logic [HEIGHT_W-1:0] screen_height_q;
	logic [COLOR_W-1:0]  ceiling_color_q;
	logic [COLOR_W-1:0]  floor_color_q;

	logic en;

	logic [HW-1:0]     h_sat;
	logic [DIST_W-1:0] dist_c;
	logic [PW-1:0]     tx_prod;
	logic [QW-1:0]     tx_raw;
	logic [QW-1:0]     tx_c;
	logic [QW-1:0]     tx_m;
	wcm_pass_t         pass_in;

	logic               valid_s1;
	logic [NW-1:0]      num_s1;
	logic [DIST_W-1:0]  dist_s1;
	logic [SIDE1_W-1:0] side_s1;

	logic               d1_done;
	logic [LW-1:0]      d1_quo;
	logic [SIDE1_W-1:0] d1_side;
	wcm_pass_t          d1_pass;
	logic [ROW_W-1:0]   d1_row;
	logic [HW-1:0]      d1_h;

	logic               st_done;
	logic [LW+QW-1:0]   st_dividend;
	logic [LW-1:0]      st_divisor;
	region_t            st_region;
	wcm_pass_t          st_pass;

	logic               d2_done;
	logic [QW-1:0]      d2_quo;
	logic [SIDE2_W-1:0] d2_side;
	wcm_pass_t          d2_pass;
	logic [1:0]         d2_region_bits;
	region_t            d2_region;
	logic [QW-1:0]      ty_c;
	rsp_word_t          word_nx;

	logic      rsp_valid_q;
	rsp_word_t rsp_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_height_q <= SCREEN_HEIGHT_RST;
			ceiling_color_q <= '0;
			floor_color_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data[HEIGHT_W-1:0];
				CFG_CEILING_COLOR: ceiling_color_q <= cfg_data[COLOR_W-1:0];
				CFG_FLOOR_COLOR:   floor_color_q   <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign en        = !rsp_valid_q || rsp_ready;
	assign req_ready = en;

	// front stage
	assign h_sat   = (32'(screen_height_q) > MAX_ROWS) ? HW'(MAX_ROWS) : HW'(screen_height_q);
	assign dist_c  = (req.wall_distance < DIST_W'(DIST_MIN)) ? DIST_W'(DIST_MIN)
	                                                        : req.wall_distance;
	assign tx_prod = PW'(req.hit_fraction) * PW'(TEX_SIZE);
	assign tx_raw  = tx_prod[FRAC_W +: QW];
	assign tx_c    = (tx_raw >= QW'(TEX_SIZE)) ? QW'(TEX_SIZE - 1) : tx_raw;
	// faces 0 and 3 read the texture mirrored
	assign tx_m    = (req.wall_face == 2'd0 || req.wall_face == 2'd3)
	                 ? (QW'(TEX_SIZE - 1) - tx_c) : tx_c;

	assign pass_in.wall_face = req.wall_face;
	assign pass_in.column    = req.column;
	assign pass_in.texel_x   = TEXEL_W'(tx_m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= {h_sat, {DIST_FRAC_BITS{1'b0}}};
			dist_s1 <= dist_c;
			side_s1 <= {pass_in, req.row, h_sat};
		end
	end

	// strip height = (H << frac) / distance
	wcm_pipe_div #(
		.DIVIDEND_W(NW),
		.DIVISOR_W (DIST_W),
		.QUOT_W    (LW),
		.SIDE_W    (SIDE1_W)
	) u_len_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.start    (valid_s1),
		.dividend (num_s1),
		.divisor  (dist_s1),
		.side     (side_s1),
		.done     (d1_done),
		.quotient (d1_quo),
		.done_side(d1_side)
	);

	assign {d1_pass, d1_row, d1_h} = d1_side;

	wcm_strip_calc #(
		.HW      (HW),
		.LW      (LW),
		.QW      (QW),
		.TEX_SIZE(TEX_SIZE)
	) u_strip (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.start    (d1_done),
		.strip_len(d1_quo),
		.height   (d1_h),
		.row      (d1_row),
		.pass     (d1_pass),
		.done     (st_done),
		.dividend (st_dividend),
		.divisor  (st_divisor),
		.region   (st_region),
		.done_pass(st_pass)
	);

	// texel row = (row - start) * TEX_SIZE / strip height
	wcm_pipe_div #(
		.DIVIDEND_W(LW + QW),
		.DIVISOR_W (LW),
		.QUOT_W    (QW),
		.SIDE_W    (SIDE2_W)
	) u_row_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.start    (st_done),
		.dividend (st_dividend),
		.divisor  (st_divisor),
		.side     ({st_pass, st_region}),
		.done     (d2_done),
		.quotient (d2_quo),
		.done_side(d2_side)
	);

	assign {d2_pass, d2_region_bits} = d2_side;
	assign d2_region = region_t'(d2_region_bits);
	assign ty_c      = (d2_quo >= QW'(TEX_SIZE)) ? QW'(TEX_SIZE - 1) : d2_quo;

	always_comb begin
		word_nx            = '0;
		word_nx.region     = d2_region;
		word_nx.face_out   = d2_pass.wall_face;
		word_nx.column_out = d2_pass.column;
		case (d2_region)
			REGION_CEILING: word_nx.flat_color = ceiling_color_q;
			REGION_FLOOR:   word_nx.flat_color = floor_color_q;
			REGION_WALL: begin
				word_nx.texel_x = d2_pass.texel_x;
				word_nx.texel_y = TEXEL_W'(ty_c);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= d2_done;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_word_q <= word_nx;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_word_q;

endmodule

FILE: sv/wcm_pipe_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module wcm_pipe_div #(
	parameter int DIVIDEND_W = 22,
	parameter int DIVISOR_W  = 20,
	parameter int QUOT_W     = 17,
	parameter int SIDE_W     = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	input  logic [SIDE_W-1:0]    side,
	output logic                 done,
	output logic [QUOT_W-1:0]    quotient,
	output logic [SIDE_W-1:0]    done_side
);

	// quotient is known to fit QUOT_W bits, so the top dividend bits seed the remainder
	localparam int RW = DIVISOR_W;

	logic                 valid_s [QUOT_W];
	logic [RW-1:0]        rem_s   [QUOT_W];
	logic [QUOT_W-1:0]    quo_s   [QUOT_W];
	logic [QUOT_W-1:0]    low_s   [QUOT_W];
	logic [DIVISOR_W-1:0] dvs_s   [QUOT_W];
	logic [SIDE_W-1:0]    side_s  [QUOT_W];

	genvar k;
	for (k = 0; k < QUOT_W; k++) begin : g_step
		logic                 v_prev;
		logic [RW-1:0]        rem_prev;
		logic [QUOT_W-1:0]    quo_prev;
		logic [QUOT_W-1:0]    low_prev;
		logic [DIVISOR_W-1:0] dvs_prev;
		logic [SIDE_W-1:0]    side_prev;
		logic [RW:0]          trial;
		logic                 take;

		if (k == 0) begin : g_first
			assign v_prev    = start;
			assign rem_prev  = RW'(dividend >> QUOT_W);
			assign quo_prev  = '0;
			assign low_prev  = dividend[QUOT_W-1:0];
			assign dvs_prev  = divisor;
			assign side_prev = side;
		end else begin : g_next
			assign v_prev    = valid_s[k-1];
			assign rem_prev  = rem_s[k-1];
			assign quo_prev  = quo_s[k-1];
			assign low_prev  = low_s[k-1];
			assign dvs_prev  = dvs_s[k-1];
			assign side_prev = side_s[k-1];
		end

		assign trial = {rem_prev, low_prev[QUOT_W-1]};
		assign take  = (trial >= {1'b0, dvs_prev});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? RW'(trial - {1'b0, dvs_prev}) : RW'(trial);
				quo_s[k]  <= (quo_prev << 1) | QUOT_W'(take);
				low_s[k]  <= low_prev << 1;
				dvs_s[k]  <= dvs_prev;
				side_s[k] <= side_prev;
			end
		end
	end

	assign done      = valid_s[QUOT_W-1];
	assign quotient  = quo_s[QUOT_W-1];
	assign done_side = side_s[QUOT_W-1];

endmodule

FILE: sv/wcm_strip_calc.sv
// Strip bounds, pixel region and texel row dividend, two register stages.
module wcm_strip_calc
	import wcm_pkg::*;
#(
	parameter int HW       = 12,
	parameter int LW       = 17,
	parameter int QW       = 7,
	parameter int TEX_SIZE = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             start,
	input  logic [LW-1:0]    strip_len,
	input  logic [HW-1:0]    height,
	input  logic [ROW_W-1:0] row,
	input  wcm_pass_t        pass,
	output logic             done,
	output logic [LW+QW-1:0] dividend,
	output logic [LW-1:0]    divisor,
	output region_t          region,
	output wcm_pass_t        done_pass
);

	localparam int SW = LW + 1;
	localparam int OW = LW + QW;

	logic [LW-1:0]        lh;
	logic signed [SW-1:0] half_h;
	logic signed [SW-1:0] half_l;

	logic                 valid_s1;
	logic [LW-1:0]        lh_s1;
	logic signed [SW-1:0] ys_s1;
	logic signed [SW-1:0] ye_s1;
	logic [HW-1:0]        h_s1;
	logic [ROW_W-1:0]     row_s1;
	logic                 outside_s1;
	wcm_pass_t            pass_s1;

	logic signed [SW-1:0] h_sx;
	logic signed [SW-1:0] row_sx;
	logic signed [SW-1:0] y0;
	logic signed [SW-1:0] y1;
	logic signed [SW-1:0] off;
	region_t              region_nx;

	logic                 valid_s2;
	logic [OW-1:0]        dividend_s2;
	logic [LW-1:0]        lh_s2;
	region_t              region_s2;
	wcm_pass_t            pass_s2;

	assign lh     = (strip_len == '0) ? LW'(1) : strip_len;
	assign half_h = SW'(height >> 1);
	assign half_l = SW'(lh >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lh_s1      <= lh;
			ys_s1      <= half_h - half_l;
			ye_s1      <= half_h + half_l;
			h_s1       <= height;
			row_s1     <= row;
			outside_s1 <= (32'(row) >= 32'(height));
			pass_s1    <= pass;
		end
	end

	assign h_sx   = SW'(h_s1);
	assign row_sx = SW'(row_s1);
	assign y0     = (ys_s1 < 0) ? '0 : ys_s1;
	assign y1     = (ye_s1 >= h_sx) ? (h_sx - SW'(1)) : ye_s1;
	assign off    = row_sx - ys_s1;

	always_comb begin
		if (outside_s1) begin
			region_nx = REGION_OUTSIDE;
		end else if (row_sx < y0) begin
			region_nx = REGION_CEILING;
		end else if (row_sx > y1) begin
			region_nx = REGION_FLOOR;
		end else begin
			region_nx = REGION_WALL;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dividend_s2 <= OW'(off[LW-1:0]) * OW'(TEX_SIZE);
			lh_s2       <= lh_s1;
			region_s2   <= region_nx;
			pass_s2     <= pass_s1;
		end
	end

	assign done      = valid_s2;
	assign dividend  = dividend_s2;
	assign divisor   = lh_s2;
	assign region    = region_s2;
	assign done_pass = pass_s2;

endmodule
